FILE: rtl/dps_pkg.sv
// shared types and constants for the double ended push stack
// depends on nothing; imported by dps_ram and double_ended_push_stack
package dps_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int WORD_WIDTH_DEF = 32;

  // operation codes
  localparam logic [2:0] OP_PUSH_TOP    = 3'd0;
  localparam logic [2:0] OP_PUSH_BOTTOM = 3'd1;
  localparam logic [2:0] OP_POP_TOP     = 3'd2;
  localparam logic [2:0] OP_CLEAR       = 3'd3;
  localparam logic [2:0] OP_QUERY       = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] item_value;
  } dps_in_t;

  typedef struct packed {
    logic [31:0] popped_value;
    logic        pop_valid;
    logic [31:0] top_value;
    logic        is_empty;
    logic [4:0]  entry_count;
    logic [1:0]  status;
  } dps_out_t;

endpackage

FILE: rtl/dps_ram.sv
// entry store: one write port, one registered read port
// write-first forwarding when both ports hit the same entry; uses dps_pkg defaults
module dps_ram #(
  parameter int DEPTH = dps_pkg::DEPTH_DEF,
  parameter int WIDTH = dps_pkg::WORD_WIDTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  import dps_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // new data wins when the read hits the entry being written
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/double_ended_push_stack.sv
// Double ended push stack: a ring of DEPTH words pushed at the top or bottom and popped
// at the top. The block takes one operation per clock (busy is high only during reset)
// and gives its result on the out_ ports in the cycle right after the accepting edge,
// marked by out_valid for that one cycle; the receiver cannot stall. The entry store is
// a single-port-write, registered-read memory that always holds the current top word on
// its read port, so a pop never waits. A push to a full store is dropped with status
// full, a pop from an empty store reports status empty; clear empties the store at once.
// depends on dps_pkg and dps_ram
module double_ended_push_stack #(
  parameter int DEPTH      = dps_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = dps_pkg::WORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dps_pkg::dps_in_t   in_data,
  output logic               out_valid,
  output dps_pkg::dps_out_t  out_data
);
  import dps_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [AW-1:0]         top_r, top_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  out_valid_r;
  logic [WORD_WIDTH-1:0] popped_r, popped_nxt;
  logic                  pop_valid_r, pop_valid_nxt;
  logic [1:0]            status_r, status_nxt;

  logic                  accept;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [WORD_WIDTH-1:0] wr_word;
  logic [WORD_WIDTH-1:0] top_word;
  logic [AW:0]           bot_sum;
  logic [AW-1:0]         bot_addr;
  logic [AW-1:0]         top_dec;
  logic [AW-1:0]         top_inc;

  // no beat is taken while reset holds the state
  assign busy   = !rst_n;
  assign accept = start && !busy;

  assign wr_word = WORD_WIDTH'(in_data.item_value);

  // slot just below the bottom word, count is below DEPTH whenever it is used
  assign bot_sum  = {1'b0, top_r} + (AW+1)'(count_r);
  assign bot_addr = (bot_sum >= (AW+1)'(DEPTH)) ? AW'(bot_sum - (AW+1)'(DEPTH))
                                                 : bot_sum[AW-1:0];
  assign top_dec  = (top_r == '0) ? LAST_IDX : top_r - AW'(1);
  assign top_inc  = (top_r == LAST_IDX) ? '0 : top_r + AW'(1);

  always_comb begin
    top_nxt       = top_r;
    count_nxt     = count_r;
    popped_nxt    = '0;
    pop_valid_nxt = 1'b0;
    status_nxt    = ST_OK;
    wr_en         = 1'b0;
    wr_addr       = top_r;
    if (accept) begin
      unique case (in_data.opcode)
        OP_PUSH_TOP: begin
          if (count_r >= FULL_CNT) begin
            status_nxt = ST_FULL;
          end else begin
            top_nxt   = top_dec;
            wr_en     = 1'b1;
            wr_addr   = top_dec;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_PUSH_BOTTOM: begin
          if (count_r >= FULL_CNT) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = bot_addr;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_POP_TOP: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            popped_nxt    = top_word;
            pop_valid_nxt = 1'b1;
            top_nxt       = top_inc;
            count_nxt     = count_r - CW'(1);
          end
        end
        OP_CLEAR: begin
          top_nxt   = '0;
          count_nxt = '0;
        end
        default: begin
          // query and unused codes leave the state alone
        end
      endcase
    end
  end

  // read port always follows the next top, so top_word is the top between beats
  dps_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_word),
    .raddr (top_nxt),
    .rdata (top_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      top_r       <= top_nxt;
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r    <= popped_nxt;
      pop_valid_r <= pop_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_data.popped_value = 32'(popped_r);
  assign out_data.pop_valid    = pop_valid_r;
  assign out_data.top_value    = (count_r == '0) ? '0 : 32'(top_word);
  assign out_data.is_empty     = (count_r == '0);
  assign out_data.entry_count  = 5'(count_r);
  assign out_data.status       = status_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("no result in the cycle after start");

  a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pop_valid |-> out_data.status == ST_OK)
    else $error("pop reported with a failure status");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |-> count_r == FULL_CNT && $stable(count_r))
    else $error("dropped push changed the count");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY) |-> count_r == '0 && !out_data.pop_valid)
    else $error("empty pop with stored entries");

endmodule

FILE: tb/tb_double_ended_push_stack.sv
// self-checking testbench for double_ended_push_stack: directed and random push/pop/clear/query beats
// with a shadow stack that predicts every result; depends on dps_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_double_ended_push_stack;
  import dps_pkg::*;

  localparam int RING = DEPTH_DEF;
  localparam int IDLE_LIMIT = 1000;

  // shadow of the ring store: predicts one report per accepted beat
  class stack_shadow_t;
    logic [31:0] slots [RING];
    int top_ptr;
    int fill;
    dps_out_t awaited_reports [$];
    int mismatches;
    int beats;
    int reports;
    int full_drops;
    int empty_pops;
    int clears;
    int peak_fill;

    function new();
      top_ptr = 0;
      fill = 0;
      mismatches = 0;
      beats = 0;
      reports = 0;
      full_drops = 0;
      empty_pops = 0;
      clears = 0;
      peak_fill = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void predict_report(dps_in_t b);
      dps_out_t r;
      r = '0;
      r.status = ST_OK;
      beats++;
      case (b.opcode)
        OP_PUSH_TOP, OP_PUSH_BOTTOM: begin
          if (fill >= RING) begin
            r.status = ST_FULL;
            full_drops++;
          end else if (b.opcode == OP_PUSH_TOP) begin
            top_ptr = (top_ptr + RING - 1) % RING;
            slots[top_ptr] = b.item_value;
            fill++;
          end else begin
            slots[(top_ptr + fill) % RING] = b.item_value;
            fill++;
          end
        end
        OP_POP_TOP: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
            empty_pops++;
          end else begin
            r.popped_value = slots[top_ptr];
            r.pop_valid = 1'b1;
            top_ptr = (top_ptr + 1) % RING;
            fill--;
          end
        end
        OP_CLEAR: begin
          top_ptr = 0;
          fill = 0;
          clears++;
        end
        default: ;  // query and unused codes leave the store alone
      endcase
      if (fill > peak_fill) peak_fill = fill;
      r.top_value = (fill != 0) ? slots[top_ptr] : '0;
      r.is_empty = (fill == 0);
      r.entry_count = fill[4:0];
      awaited_reports.push_back(r);
    endfunction

    function void field_diff(string name, logic [31:0] want_f, logic [31:0] got_f);
      if (got_f !== want_f) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want_f, got_f);
        mismatches++;
      end
    endfunction

    function void compare_report(dps_out_t got);
      dps_out_t want;
      reports++;
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        mismatches++;
        return;
      end
      want = awaited_reports.pop_front();
      field_diff("popped_value", want.popped_value, got.popped_value);
      field_diff("pop_valid", 32'(want.pop_valid), 32'(got.pop_valid));
      field_diff("top_value", want.top_value, got.top_value);
      field_diff("is_empty", 32'(want.is_empty), 32'(got.is_empty));
      field_diff("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      field_diff("status", 32'(want.status), 32'(got.status));
    endfunction

    function int outstanding();
      return awaited_reports.size();
    endfunction
  endclass

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  dps_in_t  in_data = '0;
  logic     out_valid;
  dps_out_t out_data;

  stack_shadow_t shadow = new();
  int burst_left = 0;
  int idle_cycles = 0;

  double_ended_push_stack dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // result first, then the beat accepted at this same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) shadow.compare_report(out_data);
      if (start && !busy) shadow.predict_report(in_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [2:0] op, input logic [31:0] val);
    dps_in_t b;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    b.opcode = op;
    b.item_value = val;
    start <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_op(phase_t ph);
    int roll;
    logic [2:0] push_op;
    roll = $urandom_range(0, 99);
    push_op = $urandom_range(0, 1) ? OP_PUSH_TOP : OP_PUSH_BOTTOM;
    case (ph)
      PH_FILL:  return (roll < 85) ? push_op : ((roll < 95) ? OP_POP_TOP : OP_QUERY);
      PH_DRAIN: return (roll < 85) ? OP_POP_TOP : ((roll < 95) ? push_op : OP_QUERY);
      PH_MIXED: begin
        if (roll < 45) return push_op;
        if (roll < 90) return OP_POP_TOP;
        if (roll < 95) return OP_QUERY;
        return OP_CLEAR;
      end
      default:  return 3'($urandom_range(0, 7));
    endcase
  endfunction

  initial begin
    int n_random;
    int span;
    int waited;
    phase_t ph;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty store, word extremes, both push ends, pop on empty, clear, unused codes
    send_beat(OP_QUERY, 32'h0000_0000);
    send_beat(OP_POP_TOP, 32'hFFFF_FFFF);
    send_beat(OP_PUSH_TOP, 32'h0000_0000);
    send_beat(OP_PUSH_BOTTOM, 32'hFFFF_FFFF);
    send_beat(OP_PUSH_TOP, 32'h5A5A_5A5A);
    send_beat(OP_PUSH_BOTTOM, 32'hA5A5_A5A5);
    send_beat(OP_QUERY, 32'h1234_5678);
    send_beat(OP_POP_TOP, 32'h0);
    send_beat(OP_POP_TOP, 32'h0);
    send_beat(OP_POP_TOP, 32'h0);
    send_beat(OP_POP_TOP, 32'h0);
    send_beat(OP_POP_TOP, 32'h0);
    send_beat(OP_PUSH_BOTTOM, 32'h8000_0001);
    send_beat(OP_PUSH_TOP, 32'h7FFF_FFFE);
    send_beat(OP_CLEAR, 32'hDEAD_BEEF);
    send_beat(OP_QUERY, 32'h0);
    send_beat(OP_POP_TOP, 32'h0);
    send_beat(OP_PUSH_TOP, 32'hCAFE_F00D);
    send_beat(3'd5, 32'hFFFF_FFFF);
    send_beat(3'd6, 32'h0);
    send_beat(3'd7, 32'h1111_1111);
    send_beat(OP_CLEAR, 32'h0);

    // random phases: filling runs hit the full case, draining runs hit the empty case
    n_random = 0;
    while (n_random < 400) begin
      ph = phase_t'($urandom_range(0, 3));
      span = $urandom_range(10, 30);
      repeat (span) begin
        send_beat(pick_op(ph), pick_word());
        n_random++;
      end
    end
    start <= 1'b0;

    waited = 0;
    while (shadow.outstanding() != 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    if (shadow.outstanding() != 0) begin
      $display("%0t: %0d results never arrived", $time, shadow.outstanding());
      $display("TB_ERROR");
      $finish;
    end else begin
      repeat (4) @(posedge clk);
      $display("covered %0d beats, %0d results, peak fill %0d of %0d",
               shadow.beats, shadow.reports, shadow.peak_fill, RING);
      $display("pushes dropped on full %0d, pops on empty %0d, clears %0d, mismatches %0d",
               shadow.full_drops, shadow.empty_pops, shadow.clears, shadow.mismatches);
      if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
        $display("TB_OK");
      end else begin
        $display("TB_ERROR");
      end
      $finish;
    end
  end

endmodule
